@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL, empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLBC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLBC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLBC_ASSERT(label, clk, rst_n, prop, msg)
`define PLBC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/plbc_pkg.sv @@
// Types, codes and helpers for the power LED breathing controller.
`timescale 1ns / 1ps
package plbc_pkg;

    typedef enum logic [3:0] {
        FUNC_TICK      = 4'd0,
        FUNC_SUSPEND   = 4'd1,
        FUNC_RESUME    = 4'd2,
        FUNC_SHUTDOWN  = 4'd3,
        FUNC_ALERT_ON  = 4'd4,
        FUNC_ALERT_OFF = 4'd5,
        FUNC_CRITICAL  = 4'd6,
        FUNC_MANUAL    = 4'd7,
        FUNC_SET_AUTO  = 4'd8
    } func_t;

    localparam logic [1:0] COLOUR_OFF   = 2'd0;
    localparam logic [1:0] COLOUR_RED   = 2'd1;
    localparam logic [1:0] COLOUR_GREEN = 2'd2;
    localparam logic [1:0] COLOUR_AMBER = 2'd3;

    localparam logic [1:0] CHIPSET_ON        = 2'd0;
    localparam logic [1:0] CHIPSET_SUSPENDED = 2'd1;
    localparam logic [1:0] CHIPSET_OFF       = 2'd2;

    localparam logic [1:0] CFG_BREATHE_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_BREATHE_STEP     = 2'd1;
    localparam logic [1:0] CFG_BLINK_INTERVAL   = 2'd2;

    localparam logic [6:0] LEVEL_MAX     = 7'd100;
    localparam logic [7:0] BLINK_DELTA   = 8'sd100;
    localparam logic [7:0] DUTY_MAX      = 8'd100;
    localparam logic [2:0] COLOR_IN_MAX  = 3'd3;

    localparam logic [15:0] BREATHE_INTERVAL_RST = 16'd40;
    localparam logic [6:0]  BREATHE_STEP_RST     = 7'd2;
    localparam logic [15:0] BLINK_INTERVAL_RST   = 16'd1000;

    typedef struct packed {
        logic [15:0] breathe_interval;
        logic [6:0]  breathe_step;
        logic [15:0] blink_interval;
    } cfg_t;

    typedef struct packed {
        logic [6:0]        red_level;
        logic [6:0]        green_level;
        logic [6:0]        pulse_level;
        logic signed [7:0] pulse_delta;
        logic [1:0]        pulse_colour;
        logic              running;
        logic              auto_on;
        logic              pwm_active;
    } led_state_t;

    function automatic logic [6:0] show_red(input logic [1:0] colour, input logic [6:0] level);
        show_red = (colour == COLOUR_RED || colour == COLOUR_AMBER) ? level : 7'd0;
    endfunction

    function automatic logic [6:0] show_green(input logic [1:0] colour,
                                              input logic [6:0] level);
        show_green = (colour == COLOUR_GREEN || colour == COLOUR_AMBER) ? level : 7'd0;
    endfunction

endpackage

@@ hw/rtl/plbc_core.sv @@
// Next-state logic for one item: event decode, pulse stepping, solid and manual colour.
`timescale 1ns / 1ps
module plbc_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  plbc_pkg::led_state_t   cur,
    input  logic [COUNT_WIDTH-1:0] countdown,
    input  logic [COUNT_WIDTH-1:0] period,
    input  plbc_pkg::cfg_t         cfg,
    input  logic [3:0]             func,
    input  logic [2:0]             color,
    input  logic [7:0]             duty,
    input  logic [1:0]             chipset_state,
    input  logic                   enable,
    output plbc_pkg::led_state_t   nxt,
    output logic [COUNT_WIDTH-1:0] countdown_next,
    output logic [COUNT_WIDTH-1:0] period_next,
    output logic                   status_next
);
    import plbc_pkg::*;

    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    logic [COUNT_WIDTH-1:0] breathe_period;
    logic [COUNT_WIDTH-1:0] blink_period;
    logic [6:0]             step_sat;

    logic                   start;
    logic                   act;
    logic                   solid;
    logic                   manual;
    logic                   dec;
    logic [COUNT_WIDTH-1:0] st_period;
    logic signed [7:0]      st_delta;
    logic [1:0]             st_colour;
    logic [1:0]             solid_colour;
    logic [6:0]             solid_level;

    logic [6:0]             base_level;
    logic signed [7:0]      base_delta;
    logic [1:0]             base_colour;
    logic [COUNT_WIDTH-1:0] base_period;
    logic signed [8:0]      trial;
    logic signed [7:0]      new_delta;
    logic signed [8:0]      stepped;
    logic [6:0]             clamped;

    // Zero period counts as one tick, wide periods saturate to the counter range.
    function automatic logic [COUNT_WIDTH-1:0] fit_period(input logic [15:0] raw);
        logic [32:0] ext;
        ext = {17'd0, raw};
        if (raw == 16'd0)
            fit_period = COUNT_WIDTH'(1);
        else if (ext > COUNT_MAX)
            fit_period = COUNT_MAX[COUNT_WIDTH-1:0];
        else
            fit_period = ext[COUNT_WIDTH-1:0];
    endfunction

    assign breathe_period = fit_period(cfg.breathe_interval);
    assign blink_period   = fit_period(cfg.blink_interval);
    assign step_sat       = (cfg.breathe_step > LEVEL_MAX) ? LEVEL_MAX : cfg.breathe_step;

    // Decode the event.
    always_comb
    begin
        start        = 1'b0;
        act          = 1'b0;
        solid        = 1'b0;
        manual       = 1'b0;
        dec          = 1'b0;
        status_next  = 1'b0;
        st_period    = breathe_period;
        st_delta     = $signed({1'b0, step_sat});
        st_colour    = COLOUR_GREEN;
        solid_colour = COLOUR_OFF;
        solid_level  = 7'd0;
        case (func_t'(func))
            FUNC_TICK:
            begin
                if (cur.running)
                begin
                    if (countdown > COUNT_WIDTH'(1))
                        dec = 1'b1;
                    else
                        act = 1'b1;
                end
            end
            FUNC_SUSPEND:
            begin
                start = 1'b1;
                act   = 1'b1;
            end
            FUNC_RESUME:
            begin
                solid        = 1'b1;
                solid_colour = COLOUR_GREEN;
                solid_level  = LEVEL_MAX;
            end
            FUNC_SHUTDOWN:
            begin
                solid = 1'b1;
            end
            FUNC_ALERT_ON:
            begin
                start     = 1'b1;
                act       = 1'b1;
                st_period = blink_period;
                st_delta  = BLINK_DELTA;
                st_colour = COLOUR_RED;
            end
            FUNC_ALERT_OFF:
            begin
                case (chipset_state)
                    CHIPSET_ON:
                    begin
                        solid        = 1'b1;
                        solid_colour = COLOUR_GREEN;
                        solid_level  = LEVEL_MAX;
                    end
                    CHIPSET_SUSPENDED:
                    begin
                        start = 1'b1;
                        act   = 1'b1;
                    end
                    CHIPSET_OFF:
                    begin
                        solid = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            FUNC_CRITICAL:
            begin
                solid        = 1'b1;
                solid_colour = COLOUR_RED;
                solid_level  = LEVEL_MAX;
            end
            FUNC_MANUAL:
            begin
                if (color > COLOR_IN_MAX || duty > DUTY_MAX)
                    status_next = 1'b1;
                else
                    manual = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Pulse step: reverse at the ends, then clamp to 0..100.
    always_comb
    begin
        base_level  = start ? 7'd0 : cur.pulse_level;
        base_delta  = start ? st_delta : cur.pulse_delta;
        base_colour = start ? st_colour : cur.pulse_colour;
        base_period = start ? st_period : period;
        trial       = $signed({2'b00, base_level}) + 9'(base_delta);
        new_delta   = (trial > 9'sd100 || trial < 9'sd0) ? -base_delta : base_delta;
        stepped     = $signed({2'b00, base_level}) + 9'(new_delta);
        if (stepped > 9'sd100)
            clamped = LEVEL_MAX;
        else if (stepped < 9'sd0)
            clamped = 7'd0;
        else
            clamped = stepped[6:0];
    end

    always_comb
    begin
        nxt            = cur;
        countdown_next = countdown;
        period_next    = period;
        if (start)
        begin
            nxt.pulse_level  = base_level;
            nxt.pulse_delta  = base_delta;
            nxt.pulse_colour = base_colour;
            period_next      = base_period;
        end
        if (dec)
            countdown_next = countdown - COUNT_WIDTH'(1);
        if (act)
        begin
            nxt.pwm_active = 1'b1;
            if (cur.auto_on)
            begin
                nxt.red_level   = show_red(base_colour, base_level);
                nxt.green_level = show_green(base_colour, base_level);
                nxt.pulse_level = clamped;
                nxt.pulse_delta = new_delta;
            end
            countdown_next = base_period;
            nxt.running    = 1'b1;
        end
        if (solid)
        begin
            nxt.running = 1'b0;
            if (cur.auto_on)
            begin
                nxt.red_level   = show_red(solid_colour, solid_level);
                nxt.green_level = show_green(solid_colour, solid_level);
            end
        end
        if (manual)
        begin
            nxt.red_level   = show_red(color[1:0], duty[6:0]);
            nxt.green_level = show_green(color[1:0], duty[6:0]);
        end
        if (func_t'(func) == FUNC_SET_AUTO)
            nxt.auto_on = enable;
    end

endmodule

@@ hw/rtl/power_led_mode_and_breathing_controller.sv @@
// An item passes the input register, then the result register, before it reaches the outputs.
// Throughput: one item per cycle when not stalled, set by the single-pass LED state update.
// A stalled result holds the result register and, one item later, the input register.
// Reset (rst_n low, asynchronous): LED off, no pulsing, automatic control on,
// registers back to breathe interval 40, step 2, blink interval 1000.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module power_led_mode_and_breathing_controller #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  func,
    input  logic [2:0]  color,
    input  logic [7:0]  duty,
    input  logic [1:0]  chipset_state,
    input  logic        enable,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  red_out,
    output logic [6:0]  green_out,
    output logic        pwm_on,
    output logic        status
);
    import plbc_pkg::*;

    cfg_t                   cfg_reg;
    logic                   s1_valid_reg;
    logic [3:0]             s1_func_reg;
    logic [2:0]             s1_color_reg;
    logic [7:0]             s1_duty_reg;
    logic [1:0]             s1_cs_reg;
    logic                   s1_enable_reg;
    led_state_t             state_reg;
    led_state_t             state_next;
    logic [COUNT_WIDTH-1:0] countdown_reg;
    logic [COUNT_WIDTH-1:0] countdown_next;
    logic [COUNT_WIDTH-1:0] period_reg;
    logic [COUNT_WIDTH-1:0] period_next;
    logic                   status_reg;
    logic                   status_next;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   in_take;
    logic                   level_ok;
    logic                   count_ok;
    logic                   out_held;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.breathe_interval <= BREATHE_INTERVAL_RST;
            cfg_reg.breathe_step     <= BREATHE_STEP_RST;
            cfg_reg.blink_interval   <= BLINK_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BREATHE_INTERVAL: cfg_reg.breathe_interval <= cfg_data;
                CFG_BREATHE_STEP:     cfg_reg.breathe_step     <= cfg_data[6:0];
                CFG_BLINK_INTERVAL:   cfg_reg.blink_interval   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg   <= func;
            s1_color_reg  <= color;
            s1_duty_reg   <= duty;
            s1_cs_reg     <= chipset_state;
            s1_enable_reg <= enable;
        end
    end

    plbc_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .cur            (state_reg),
        .countdown      (countdown_reg),
        .period         (period_reg),
        .cfg            (cfg_reg),
        .func           (s1_func_reg),
        .color          (s1_color_reg),
        .duty           (s1_duty_reg),
        .chipset_state  (s1_cs_reg),
        .enable         (s1_enable_reg),
        .nxt            (state_next),
        .countdown_next (countdown_next),
        .period_next    (period_next),
        .status_next    (status_next)
    );

    // LED state doubles as the result register: it moves only when the next result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.red_level    <= 7'd0;
            state_reg.green_level  <= 7'd0;
            state_reg.pulse_level  <= 7'd0;
            state_reg.pulse_delta  <= 8'sd0;
            state_reg.pulse_colour <= COLOUR_OFF;
            state_reg.running      <= 1'b0;
            state_reg.auto_on      <= 1'b1;
            state_reg.pwm_active   <= 1'b0;
            countdown_reg          <= '0;
            period_reg             <= '0;
            status_reg             <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                countdown_reg <= countdown_next;
                period_reg    <= period_next;
                status_reg    <= status_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = state_reg.red_level;
    assign green_out = state_reg.green_level;
    assign pwm_on    = state_reg.pwm_active;
    assign status    = status_reg;

    assign level_ok = state_reg.red_level <= LEVEL_MAX && state_reg.green_level <= LEVEL_MAX
                      && state_reg.pulse_level <= LEVEL_MAX;
    assign count_ok = !state_reg.running || countdown_reg != '0;
    assign out_held = out_valid_reg && out_stall;

    `PLBC_ASSERT(a_level_range, clk, rst_n, level_ok, "LED level above 100")
    `PLBC_ASSERT(a_running_count, clk, rst_n, count_ok, "pulse running with zero countdown")
    `PLBC_ASSERT(a_pwm_sticky, clk, rst_n, !$fell(state_reg.pwm_active), "PWM enable dropped")
    `PLBC_ASSERT(a_hold_on_stall, clk, rst_n, out_held |=> $stable(state_reg), "held state moved")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the power LED mode and breathing controller.
`timescale 1ns / 1ps
module tb;
    import plbc_pkg::*;

    localparam int LEVEL_TOP = int'(LEVEL_MAX);
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [3:0] FUNC_UNUSED_LO = 4'd9;
    localparam logic [3:0] FUNC_UNUSED_HI = 4'd15;

    typedef struct {
        logic [6:0] red;
        logic [6:0] green;
        logic       pwm;
        logic       status;
    } led_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  func;
    logic [2:0]  color;
    logic [7:0]  duty;
    logic [1:0]  chipset_state;
    logic        enable;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  red_out;
    logic [6:0]  green_out;
    logic        pwm_on;
    logic        status;

    // model of the LED state and registers
    logic [15:0] brth_ivl;
    logic [6:0]  brth_step;
    logic [15:0] blink_ivl;
    logic [6:0]  red_lvl;
    logic [6:0]  green_lvl;
    int          pulse_lvl;
    int          pulse_step;
    logic [1:0]  pulse_col;
    logic [15:0] pulse_per;
    logic [15:0] count_left;
    bit          pulsing;
    bit          auto_ctrl;
    bit          pwm_en;

    led_result_t expected_leds[$];
    int          mismatches;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;

    power_led_mode_and_breathing_controller DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .color(color),
        .duty(duty),
        .chipset_state(chipset_state),
        .enable(enable),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red_out(red_out),
        .green_out(green_out),
        .pwm_on(pwm_on),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void reset_model();
        brth_ivl = BREATHE_INTERVAL_RST;
        brth_step = BREATHE_STEP_RST;
        blink_ivl = BLINK_INTERVAL_RST;
        red_lvl = '0;
        green_lvl = '0;
        pulse_lvl = 0;
        pulse_step = 0;
        pulse_col = COLOUR_OFF;
        pulse_per = '0;
        count_left = '0;
        pulsing = 1'b0;
        auto_ctrl = 1'b1;
        pwm_en = 1'b0;
    endfunction

    function automatic void set_colour(input logic [1:0] col, input logic [6:0] lvl);
        red_lvl = (col == COLOUR_RED || col == COLOUR_AMBER) ? lvl : 7'd0;
        green_lvl = (col == COLOUR_GREEN || col == COLOUR_AMBER) ? lvl : 7'd0;
    endfunction

    function automatic void load_pulse(input logic [15:0] period, input int step,
                                       input logic [1:0] col);
        pulse_per = (period == 16'd0) ? 16'd1 : period;
        pulse_step = step;
        pulse_col = col;
        pulse_lvl = 0;
    endfunction

    function automatic void fire_pulse();
        int nxt;
        pwm_en = 1'b1;
        if (auto_ctrl)
        begin
            set_colour(pulse_col, 7'(pulse_lvl));
            nxt = pulse_lvl + pulse_step;
            // reverse at either end, then clamp the overshoot
            if (nxt > LEVEL_TOP || nxt < 0)
                pulse_step = -pulse_step;
            nxt = pulse_lvl + pulse_step;
            if (nxt > LEVEL_TOP)
                nxt = LEVEL_TOP;
            if (nxt < 0)
                nxt = 0;
            pulse_lvl = nxt;
        end
        count_left = pulse_per;
        pulsing = 1'b1;
    endfunction

    function automatic void begin_breathe();
        int s;
        s = (brth_step > LEVEL_MAX) ? LEVEL_TOP : int'(brth_step);
        load_pulse(brth_ivl, s, COLOUR_GREEN);
        fire_pulse();
    endfunction

    function automatic void go_solid(input logic [1:0] col, input logic [6:0] lvl);
        pulsing = 1'b0;
        if (auto_ctrl)
            set_colour(col, lvl);
    endfunction

    function automatic void predict_led(input logic [3:0] f, input logic [2:0] c,
                                        input logic [7:0] d, input logic [1:0] cs,
                                        input logic e);
        led_result_t r;
        r.status = 1'b0;
        case (f)
            FUNC_TICK:
                if (pulsing)
                begin
                    if (count_left > 16'd1)
                        count_left = count_left - 16'd1;
                    else
                        fire_pulse();
                end
            FUNC_SUSPEND:  begin_breathe();
            FUNC_RESUME:   go_solid(COLOUR_GREEN, LEVEL_MAX);
            FUNC_SHUTDOWN: go_solid(COLOUR_OFF, 7'd0);
            FUNC_ALERT_ON:
            begin
                load_pulse(blink_ivl, LEVEL_TOP, COLOUR_RED);
                fire_pulse();
            end
            FUNC_ALERT_OFF:
                if (cs == CHIPSET_ON)
                    go_solid(COLOUR_GREEN, LEVEL_MAX);
                else if (cs == CHIPSET_SUSPENDED)
                    begin_breathe();
                else if (cs == CHIPSET_OFF)
                    go_solid(COLOUR_OFF, 7'd0);
            FUNC_CRITICAL: go_solid(COLOUR_RED, LEVEL_MAX);
            FUNC_MANUAL:
                if (c > COLOR_IN_MAX || d > DUTY_MAX)
                    r.status = 1'b1;
                else
                    set_colour(c[1:0], d[6:0]);
            FUNC_SET_AUTO: auto_ctrl = e;
            default: ;
        endcase
        r.red = red_lvl;
        r.green = green_lvl;
        r.pwm = pwm_en;
        expected_leds.push_back(r);
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic drive_event(input logic [3:0] f, input logic [2:0] c, input logic [7:0] d,
                               input logic [1:0] cs, input logic e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        color <= c;
        duty <= d;
        chipset_state <= cs;
        enable <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_led(f, c, d, cs, e);
    endtask

    task automatic wait_empty();
        in_valid <= 1'b0;
        while (expected_leds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        wait_empty();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BREATHE_INTERVAL: brth_ivl = val;
            CFG_BREATHE_STEP:     brth_step = val[6:0];
            CFG_BLINK_INTERVAL:   blink_ivl = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] bi, input logic [15:0] bs,
                                input logic [15:0] li);
        write_reg(CFG_BREATHE_INTERVAL, bi);
        write_reg(CFG_BREATHE_STEP, bs);
        write_reg(CFG_BLINK_INTERVAL, li);
    endtask

    // Mostly ticks, with every event mixed in; payload bits always random.
    task automatic send_traffic(input int count, input int tick_pct);
        logic [3:0] f;
        logic [2:0] c;
        logic [7:0] d;
        logic       e;
        int         pick;
        for (int i = 0; i < count; i++)
        begin
            c = 3'($urandom_range(7));
            d = 8'($urandom_range(255));
            e = 1'($urandom_range(1));
            f = FUNC_TICK;
            if ($urandom_range(99) >= tick_pct)
            begin
                pick = $urandom_range(14);
                case (pick)
                    0, 1: f = FUNC_SUSPEND;
                    2:    f = FUNC_RESUME;
                    3:    f = FUNC_SHUTDOWN;
                    4, 5: f = FUNC_ALERT_ON;
                    6, 7: f = FUNC_ALERT_OFF;
                    8:    f = FUNC_CRITICAL;
                    9, 10, 11:
                    begin
                        f = FUNC_MANUAL;
                        if ($urandom_range(9) < 7)
                        begin
                            c = 3'($urandom_range(3));
                            d = 8'($urandom_range(100));
                        end
                    end
                    12, 13:
                    begin
                        f = FUNC_SET_AUTO;
                        e = ($urandom_range(9) < 8);
                    end
                    default: f = 4'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
                endcase
            end
            drive_event(f, c, d, 2'($urandom_range(3)), e);
        end
    endtask

    task automatic test_directed();
        drive_event(FUNC_TICK, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_MANUAL, 3'(COLOUR_AMBER), DUTY_MAX, CHIPSET_ON, 1'b0);
        drive_event(FUNC_MANUAL, 3'(COLOUR_OFF), 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_MANUAL, 3'd4, 8'd50, CHIPSET_ON, 1'b0);
        drive_event(FUNC_MANUAL, 3'd7, 8'd255, CHIPSET_OFF, 1'b1);
        drive_event(FUNC_MANUAL, 3'(COLOUR_RED), 8'd101, CHIPSET_ON, 1'b0);
        drive_event(FUNC_SUSPEND, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_TICK, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_ALERT_ON, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_ALERT_OFF, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_ALERT_OFF, 3'd0, 8'd0, CHIPSET_SUSPENDED, 1'b0);
        drive_event(FUNC_ALERT_OFF, 3'd0, 8'd0, CHIPSET_OFF, 1'b0);
        drive_event(FUNC_ALERT_OFF, 3'd0, 8'd0, 2'd3, 1'b0);
        drive_event(FUNC_CRITICAL, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_RESUME, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_SHUTDOWN, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        // automatic modes must not touch the LED while disabled
        drive_event(FUNC_SET_AUTO, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_SUSPEND, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_CRITICAL, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
        drive_event(FUNC_MANUAL, 3'(COLOUR_GREEN), 8'd77, CHIPSET_ON, 1'b0);
        drive_event(FUNC_SET_AUTO, 3'd0, 8'd0, CHIPSET_ON, 1'b1);
        drive_event(FUNC_UNUSED_LO, 3'd7, 8'd255, 2'd3, 1'b1);
        drive_event(FUNC_UNUSED_HI, 3'd0, 8'd0, CHIPSET_ON, 1'b0);
    endtask

    // Zero interval, zero and oversized step, largest intervals, uneven steps.
    task automatic test_register_extremes();
        program_regs(16'd0, 16'd3, 16'd0);
        send_traffic(30, 75);
        program_regs(16'd1, 16'd127, 16'd1);
        send_traffic(30, 75);
        program_regs(16'd2, 16'd0, 16'd3);
        send_traffic(30, 75);
        program_regs(16'hFFFF, 16'd100, 16'hFFFF);
        send_traffic(20, 60);
        program_regs(16'd3, 16'd7, 16'd2);
        send_traffic(30, 80);
    endtask

    task automatic test_random_phases();
        program_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 30)),
                     16'($urandom_range(1, 8)));
        send_idle_pct = 11;
        recv_idle_pct = 87;
        send_traffic(110, 70);
        program_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 30)),
                     16'($urandom_range(1, 8)));
        send_idle_pct = 87;
        recv_idle_pct = 11;
        send_traffic(110, 70);
        program_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 30)),
                     16'($urandom_range(1, 8)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_traffic(110, 70);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        send_traffic(20, 60);
        // pause the sender until every result is out, then resume
        wait_empty();
        send_traffic(10, 60);
    endtask

    // Receiver: random stall, or a long hold-off when one is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        led_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_leds.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: r=%0d g=%0d pwm=%0b st=%0b",
                             red_out, green_out, pwm_on, status);
                mismatches++;
            end
            else
            begin
                want = expected_leds.pop_front();
                if (red_out !== want.red || green_out !== want.green
                    || pwm_on !== want.pwm || status !== want.status)
                begin
                    if (mismatches < 10)
                        $display({"mismatch: exp r=%0d g=%0d pwm=%0b st=%0b,",
                                  " got r=%0d g=%0d pwm=%0b st=%0b"},
                                 want.red, want.green, want.pwm, want.status,
                                 red_out, green_out, pwm_on, status);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BREATHE_INTERVAL;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_TICK;
        color = '0;
        duty = '0;
        chipset_state = CHIPSET_ON;
        enable = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 0;
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        wait_empty();

        if (mismatches == 0 && expected_leds.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/plbc_pkg.sv
hw/rtl/plbc_core.sv
hw/rtl/power_led_mode_and_breathing_controller.sv
tb/tb.sv
